// ===== src/cwc_pkg.sv =====
package cwc_pkg;

	// fixed field widths
	localparam int OP_W   = 2;
	localparam int ADDR_W = 31;
	localparam int PAGE_W = 13;
	localparam int CAP_W  = 16;

	// defaults for the top-level parameters
	localparam int ENTRIES_DEF        = 32;
	localparam int PAGE_MAX_BYTES_DEF = 4096;

	// configuration port
	localparam int              APB_ADDR_W  = 3;
	localparam int              APB_DATA_W  = 32;
	localparam logic [CAP_W-1:0] CAP_RESET   = 16'd4096;
	localparam logic            REG_CAPACITY = 1'b0;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// result kinds
	localparam logic KIND_STATUS    = 1'b0;
	localparam logic KIND_WRITEBACK = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MV_RD,
		S_MV_WR,
		S_APPEND,
		S_FLUSH,
		S_STATUS
	} state_t;

endpackage

// ===== src/cwc_if.sv =====
interface cwc_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [cwc_pkg::OP_W-1:0]   opcode;
	logic [cwc_pkg::ADDR_W-1:0] sector_addr;
	logic [cwc_pkg::PAGE_W-1:0] page_bytes;

	modport source (output valid, opcode, sector_addr, page_bytes, input ready);
	modport sink   (input valid, opcode, sector_addr, page_bytes, output ready);
endinterface

interface cwc_res_if;
	logic                       valid;
	logic                       ready;
	logic                       result_kind;
	logic [cwc_pkg::ADDR_W-1:0] writeback_addr;
	logic                       failed;
	logic                       hit;
	logic                       last;

	modport source (output valid, result_kind, writeback_addr, failed, hit, last,
		input ready);
	modport sink   (input valid, result_kind, writeback_addr, failed, hit, last,
		output ready);
endinterface

// ===== src/cwc_core.sv =====
module cwc_core #(
	parameter int ENTRIES        = cwc_pkg::ENTRIES_DEF,
	parameter int PAGE_MAX_BYTES = cwc_pkg::PAGE_MAX_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cwc_pkg::CAP_W-1:0] capacity,
	cwc_cmd_if.sink                   cmd,
	cwc_res_if.source                 res
);
	import cwc_pkg::*;

	localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int SW    = $clog2(PAGE_MAX_BYTES + 1);
	localparam int EXT_W = (SW > PAGE_W) ? SW : PAGE_W;
	localparam int DW    = ADDR_W + SW;
	localparam int SUM_W = CAP_W + 1;

	// entry table: sector address over compressed size
	logic [DW-1:0] mem [ENTRIES];
	logic [DW-1:0] rd_data_s1;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SW-1:0]     size_q;
	logic [CW-1:0]     cnt_q;
	logic [CAP_W-1:0]  used_q;
	logic [CW-1:0]     scan_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic [IW-1:0]     found_idx_q;
	logic              retry_q;
	logic              failed_q;
	logic              hit_q;

	logic              res_vld_q;
	logic              res_kind_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_failed_q;
	logic              res_hit_q;
	logic              res_last_q;

	logic              accept;
	logic              out_free;
	logic [ADDR_W-1:0] rd_addr_f;
	logic [SW-1:0]     rd_bytes_f;
	logic [EXT_W-1:0]  pb_ext;
	logic [EXT_W-1:0]  pb_sat;
	logic              scan_issue;
	logic              scan_match;
	logic              scan_miss;
	logic              fit;
	logic              fl_go;
	logic              fl_issue;
	logic              fl_done;

	logic              rd_en;
	logic [IW-1:0]     rd_idx;
	logic              wr_en;
	logic [IW-1:0]     wr_idx;
	logic [DW-1:0]     wr_data;
	logic              load_wb;
	logic              load_status;

	// conditions
	assign accept     = cmd.valid && cmd.ready;
	assign out_free   = !res_vld_q || res.ready;
	assign rd_addr_f  = rd_data_s1[SW +: ADDR_W];
	assign rd_bytes_f = rd_data_s1[SW-1:0];
	assign pb_ext     = EXT_W'(cmd.page_bytes);
	assign pb_sat     = (pb_ext > EXT_W'(PAGE_MAX_BYTES)) ? EXT_W'(PAGE_MAX_BYTES) : pb_ext;

	assign scan_issue = (state_q == S_SCAN) && (scan_q < cnt_q);
	assign scan_match = (state_q == S_SCAN) && vld_s1 && (rd_addr_f == addr_q);
	assign scan_miss  = (state_q == S_SCAN) && !scan_match && (scan_q == cnt_q);
	assign fit        = ((SUM_W'(used_q) + SUM_W'(size_q)) <= SUM_W'(capacity))
		&& (cnt_q < CW'(ENTRIES));
	assign fl_go      = (state_q == S_FLUSH) && (!vld_s1 || out_free);
	assign fl_issue   = fl_go && (cnt_q != '0);
	assign fl_done    = fl_go && (cnt_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(cmd.opcode))
						OP_WRITE, OP_LOOKUP: state_d = S_SCAN;
						OP_FLUSH:            state_d = S_FLUSH;
						OP_CLEAR:            state_d = S_STATUS;
						default:             state_d = S_STATUS;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_match) begin
					if (op_q == OP_WRITE) begin
						state_d = (cnt_q > CW'(1)) ? S_MV_RD : S_APPEND;
					end else begin
						state_d = S_STATUS;
					end
				end else if (scan_miss) begin
					state_d = (op_q == OP_WRITE) ? S_APPEND : S_STATUS;
				end
			end
			S_MV_RD:  state_d = S_MV_WR;
			S_MV_WR:  state_d = S_APPEND;
			S_APPEND: begin
				if (fit || retry_q) begin
					state_d = S_STATUS;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (fl_done) begin
					state_d = (op_q == OP_WRITE) ? S_APPEND : S_STATUS;
				end
			end
			S_STATUS: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and result controls
	always_comb begin
		cmd.ready   = 1'b0;
		rd_en       = 1'b0;
		rd_idx      = '0;
		wr_en       = 1'b0;
		wr_idx      = '0;
		wr_data     = {addr_q, size_q};
		load_wb     = 1'b0;
		load_status = 1'b0;
		unique case (state_q)
			S_IDLE: cmd.ready = 1'b1;
			S_SCAN: begin
				rd_en  = scan_issue;
				rd_idx = scan_q[IW-1:0];
			end
			S_MV_RD: begin
				rd_en  = 1'b1;
				rd_idx = cnt_q[IW-1:0];
			end
			S_MV_WR: begin
				wr_en   = 1'b1;
				wr_idx  = found_idx_q;
				wr_data = rd_data_s1;
			end
			S_APPEND: begin
				wr_en  = fit;
				wr_idx = cnt_q[IW-1:0];
			end
			S_FLUSH: begin
				rd_en   = fl_issue;
				rd_idx  = IW'(cnt_q - CW'(1));
				load_wb = fl_go && vld_s1;
			end
			S_STATUS: load_status = out_free;
			default: ;
		endcase
	end

	// table memory, one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx];
		end
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(cmd.opcode);
			addr_q <= cmd.sector_addr;
			size_q <= SW'(pb_sat);
		end
		if (scan_issue) begin
			idx_s1 <= scan_q[IW-1:0];
		end
		if (scan_match) begin
			found_idx_q <= idx_s1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			used_q   <= '0;
			scan_q   <= '0;
			vld_s1   <= 1'b0;
			retry_q  <= 1'b0;
			failed_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= 1'b0;
			if (accept) begin
				scan_q   <= '0;
				retry_q  <= 1'b0;
				failed_q <= 1'b0;
				hit_q    <= 1'b0;
				if (op_t'(cmd.opcode) == OP_CLEAR) begin
					cnt_q  <= '0;
					used_q <= '0;
				end
			end
			// scan stage
			if (scan_issue) begin
				scan_q <= scan_q + CW'(1);
				vld_s1 <= !scan_match;
			end
			if (scan_match) begin
				hit_q <= 1'b1;
				if (op_q == OP_WRITE) begin
					cnt_q  <= cnt_q - CW'(1);
					used_q <= used_q - CAP_W'(rd_bytes_f);
				end
			end
			// append or retry
			if (state_q == S_APPEND) begin
				if (fit) begin
					cnt_q  <= cnt_q + CW'(1);
					used_q <= used_q + CAP_W'(size_q);
				end else if (retry_q) begin
					failed_q <= 1'b1;
				end else begin
					retry_q <= 1'b1;
				end
			end
			// flush walks down from the top entry
			if (state_q == S_FLUSH) begin
				if (fl_go) begin
					vld_s1 <= fl_issue;
					if (fl_issue) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end else begin
					vld_s1 <= vld_s1;
				end
				if (fl_done) begin
					used_q <= '0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (load_wb || load_status) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_wb) begin
			res_kind_q   <= KIND_WRITEBACK;
			res_addr_q   <= rd_addr_f;
			res_failed_q <= 1'b0;
			res_hit_q    <= 1'b0;
			res_last_q   <= 1'b0;
		end else if (load_status) begin
			res_kind_q   <= KIND_STATUS;
			res_addr_q   <= '0;
			res_failed_q <= failed_q;
			res_hit_q    <= hit_q && (op_q == OP_LOOKUP);
			res_last_q   <= 1'b1;
		end
	end

	assign res.valid          = res_vld_q;
	assign res.result_kind    = res_kind_q;
	assign res.writeback_addr = res_addr_q;
	assign res.failed         = res_failed_q;
	assign res.hit            = res_hit_q;
	assign res.last           = res_last_q;

`ifndef SYNTH
	// fill count never passes the table depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ENTRIES))
		else $error("entry count beyond table depth");

	// an empty table holds no bytes between items
	a_empty_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cnt_q == '0) |-> used_q == '0)
		else $error("bytes in use with an empty table");

	// read data is only pending during scan or flush
	a_rd_pending: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN || state_q == S_FLUSH))
		else $error("stray pending read");

	// leaving status always presents the final item
	a_status_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STATUS && out_free) |=>
			(res_vld_q && res_last_q && state_q == S_IDLE))
		else $error("status item not presented");
`endif

endmodule

// ===== src/compressed_write_cache.sv =====
// Byte-budgeted, fully associative write cache of up to ENTRIES pages. Each item on cmd
// (write, lookup, flush, clear) produces zero or more writeback items on res, highest table
// slot first, followed by one status item with last set. Items are handled one at a time and
// the entry table sits in a single-port-read memory, so the cost grows with the number of
// table reads: lookup reads up to every cached entry, flush reads every one, a write scans and
// may also move an entry and then flush, and clear reads none; stalls on res add to the cost.
// capacity_bytes is at byte address 0 and may only be written while the block is idle; its
// reset value is 4096.
module compressed_write_cache #(
	parameter int ENTRIES        = cwc_pkg::ENTRIES_DEF,
	parameter int PAGE_MAX_BYTES = cwc_pkg::PAGE_MAX_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cwc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cwc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cwc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	cwc_cmd_if.sink                        cmd,
	cwc_res_if.source                      res
);
	import cwc_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             sel_cap;

	assign pready  = 1'b1;
	assign sel_cap = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = sel_cap ? APB_DATA_W'(cap_q) : '0;

	cwc_core #(
		.ENTRIES        (ENTRIES),
		.PAGE_MAX_BYTES (PAGE_MAX_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (cap_q),
		.cmd      (cmd),
		.res      (res)
	);

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cwc_pkg::*;

	localparam int SLOTS = ENTRIES_DEF;
	localparam int PAGE_MAX = PAGE_MAX_BYTES_DEF;
	localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(4 * REG_CAPACITY);
	localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
	localparam int QUIET_LIMIT = 2000;
	localparam int POOL_SIZE = 48;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] wb_addr;
		logic              failed;
		logic              hit;
		logic              last;
	} cache_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cwc_cmd_if cmd_bus ();
	cwc_res_if res_bus ();

	compressed_write_cache uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_bus),
		.res     (res_bus)
	);

	// shadow copy of the cache table and budget
	logic [ADDR_W-1:0] shadow_addr [SLOTS];
	int                shadow_bytes [SLOTS];
	int                shadow_count;
	int                shadow_used;
	int                shadow_capacity;

	// results the block still owes, oldest first
	cache_res_t owed_results [$];

	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  writebacks_seen;
	int  capacity_writes;
	int  quiet_cycles;
	bit  idle_en;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic string fmt_res(cache_res_t r);
		return $sformatf("kind=%0d addr=%h failed=%0d hit=%0d last=%0d",
			r.kind, r.wb_addr, r.failed, r.hit, r.last);
	endfunction

	function automatic void report_fault(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endfunction

	// table search over the live entries only
	function automatic int find_slot(logic [ADDR_W-1:0] addr);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_addr[i] == addr)
				return i;
		return -1;
	endfunction

	function automatic bit try_fit(logic [ADDR_W-1:0] addr, int page_len);
		if (shadow_used + page_len > shadow_capacity || shadow_count >= SLOTS)
			return 1'b0;
		shadow_addr[shadow_count] = addr;
		shadow_bytes[shadow_count] = page_len;
		shadow_count++;
		shadow_used += page_len;
		return 1'b1;
	endfunction

	// writebacks go out from the highest slot down
	function automatic void evict_all();
		cache_res_t wb;
		while (shadow_count > 0) begin
			shadow_count--;
			wb = '{kind: KIND_WRITEBACK, wb_addr: shadow_addr[shadow_count],
				failed: 1'b0, hit: 1'b0, last: 1'b0};
			owed_results.push_back(wb);
		end
		shadow_used = 0;
	endfunction

	function automatic void apply_cache_op(op_t op, logic [ADDR_W-1:0] addr,
			logic [PAGE_W-1:0] page_bytes);
		cache_res_t status;
		int page_len;
		int slot;
		bit stored;
		page_len = (page_bytes > PAGE_MAX) ? PAGE_MAX : int'(page_bytes);
		status = '{kind: KIND_STATUS, wb_addr: '0, failed: 1'b0, hit: 1'b0, last: 1'b1};
		case (op)
			OP_WRITE: begin
				// drop an existing copy, last entry fills the hole
				slot = find_slot(addr);
				if (slot >= 0) begin
					shadow_used -= shadow_bytes[slot];
					shadow_count--;
					shadow_addr[slot] = shadow_addr[shadow_count];
					shadow_bytes[slot] = shadow_bytes[shadow_count];
				end
				stored = try_fit(addr, page_len);
				if (!stored) begin
					evict_all();
					stored = try_fit(addr, page_len);
				end
				status.failed = !stored;
			end
			OP_LOOKUP: status.hit = (find_slot(addr) >= 0);
			OP_FLUSH:  evict_all();
			default: begin
				shadow_count = 0;
				shadow_used = 0;
			end
		endcase
		owed_results.push_back(status);
	endfunction

	// one command item, with an optional gap in front of it
	task automatic send_item(op_t op, logic [ADDR_W-1:0] addr, logic [PAGE_W-1:0] page_bytes);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.opcode      <= op;
		cmd_bus.sector_addr <= addr;
		cmd_bus.page_bytes  <= page_bytes;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		apply_cache_op(op, addr, page_bytes);
		items_sent++;
	endtask

	task automatic wait_until_drained();
		cmd_bus.valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// apb setup and access phases; psel is left high for chaining
	task automatic apb_transfer(bit wr, logic [APB_DATA_W-1:0] wdata,
			output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CAP_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
	endtask

	task automatic verify_capacity();
		logic [APB_DATA_W-1:0] rd;
		apb_transfer(1'b0, '0, rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DATA_W'(shadow_capacity))
			report_fault($sformatf("capacity read back %h, expected %h", rd,
				APB_DATA_W'(shadow_capacity)));
	endtask

	task automatic set_capacity(int unsigned cap);
		logic [APB_DATA_W-1:0] rd;
		wait_until_drained();
		apb_transfer(1'b1, APB_DATA_W'(cap & 16'hFFFF), rd);
		shadow_capacity = cap & 16'hFFFF;
		capacity_writes++;
		verify_capacity();
	endtask

	// result checking
	always @(posedge clk) begin : res_check
		cache_res_t seen;
		cache_res_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			seen = '{kind: res_bus.result_kind, wb_addr: res_bus.writeback_addr,
				failed: res_bus.failed, hit: res_bus.hit, last: res_bus.last};
			results_seen++;
			if (seen.kind == KIND_WRITEBACK)
				writebacks_seen++;
			if (owed_results.size() == 0) begin
				report_fault({"unexpected result ", fmt_res(seen)});
			end else begin
				want = owed_results.pop_front();
				if (seen.kind !== want.kind || seen.wb_addr !== want.wb_addr ||
						seen.failed !== want.failed || seen.hit !== want.hit ||
						seen.last !== want.last)
					report_fault({"expected ", fmt_res(want), " got ", fmt_res(seen)});
			end
		end
	end

	// result back-pressure in random bursts
	initial begin : res_stall
		int stall_left;
		stall_left = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (idle_en && arst_n && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
				(psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_register_reset();
		verify_capacity();
	endtask

	// every operation, field extremes, rewrite and oversized page
	task automatic test_basic_ops();
		send_item(OP_LOOKUP, '0, '0);
		send_item(OP_FLUSH, '0, '0);
		send_item(OP_CLEAR, '0, '0);
		send_item(OP_WRITE, '0, '0);
		send_item(OP_WRITE, ADDR_ONES, '1);
		send_item(OP_LOOKUP, ADDR_ONES, '0);
		send_item(OP_LOOKUP, 31'h2AAA_AAAA, '0);
		send_item(OP_WRITE, ADDR_ONES, 13'd100);
		send_item(OP_WRITE, 31'h2AAA_AAAA, 13'd4097);
		send_item(OP_LOOKUP, '0, '0);
		send_item(OP_FLUSH, '0, '0);
		send_item(OP_WRITE, 31'h5555_5555, 13'd1);
		send_item(OP_CLEAR, ADDR_ONES, '1);
		send_item(OP_LOOKUP, 31'h5555_5555, '0);
	endtask

	// page over budget, failed rewrite, budget lowered under use, zero budget
	task automatic test_special_cases();
		set_capacity(100);
		send_item(OP_WRITE, 31'd7, 13'd60);
		send_item(OP_WRITE, 31'd7, 13'd200);
		send_item(OP_LOOKUP, 31'd7, '0);
		send_item(OP_WRITE, 31'd8, 13'd50);
		send_item(OP_WRITE, 31'd9, 13'd150);
		set_capacity(CAP_RESET);
		send_item(OP_WRITE, 31'd10, 13'd2000);
		send_item(OP_WRITE, 31'd11, 13'd2000);
		set_capacity(1000);
		send_item(OP_WRITE, 31'd12, 13'd10);
		set_capacity(0);
		send_item(OP_WRITE, 31'd13, 13'd0);
		send_item(OP_WRITE, 31'd14, 13'd1);
		set_capacity(16'hFFFF);
		send_item(OP_FLUSH, '0, '0);
	endtask

	// fill every slot, then one more write forces a full flush
	task automatic test_entry_limit();
		logic [ADDR_W-1:0] base;
		set_capacity(16'hFFFF);
		send_item(OP_CLEAR, '0, '0);
		base = ADDR_W'($urandom) & ~ADDR_W'(63);
		for (int i = 0; i <= SLOTS; i++)
			send_item(OP_WRITE, base | ADDR_W'(i), PAGE_W'($urandom_range(0, 1900)));
		send_item(OP_FLUSH, '0, '0);
	endtask

	// mostly pooled addresses so rewrites and hits are common
	task automatic run_mix(int unsigned cap, int n_items);
		op_t op;
		logic [ADDR_W-1:0] addr;
		logic [PAGE_W-1:0] len;
		int pick;
		set_capacity(cap);
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 58)
				op = OP_WRITE;
			else if (pick < 84)
				op = OP_LOOKUP;
			else if (pick < 93)
				op = OP_FLUSH;
			else
				op = OP_CLEAR;
			if ($urandom_range(0, 9) < 8)
				addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				addr = ADDR_W'($urandom);
			pick = $urandom_range(0, 9);
			if (pick < 7)
				len = PAGE_W'($urandom_range(0, 1500));
			else if (pick < 9)
				len = PAGE_W'($urandom_range(0, PAGE_MAX));
			else
				len = PAGE_W'($urandom);
			send_item(op, addr, len);
		end
	endtask

	task automatic test_random_traffic();
		run_mix(16'hFFFF, 45);
		run_mix(CAP_RESET, 40);
		run_mix($urandom_range(1, 12000), 35);
		run_mix(0, 15);
		// last stretch runs with both sides flat out
		wait_until_drained();
		idle_en = 1'b0;
		run_mix(1500, 35);
	endtask

	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		cmd_bus.valid       <= 1'b0;
		cmd_bus.opcode      <= OP_LOOKUP;
		cmd_bus.sector_addr <= '0;
		cmd_bus.page_bytes  <= '0;
		idle_en = 1'b1;
		shadow_count = 0;
		shadow_used = 0;
		shadow_capacity = CAP_RESET;
		foreach (addr_pool[i])
			addr_pool[i] = ADDR_W'($urandom);
		addr_pool[0] = '0;
		addr_pool[1] = ADDR_ONES;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reset();
		test_basic_ops();
		test_special_cases();
		test_entry_limit();
		test_random_traffic();

		wait_until_drained();
		repeat (80) @(posedge clk);

		$display("covered %0d command items over %0d budget settings, all four operations",
			items_sent, capacity_writes);
		$display("checked %0d results (%0d writebacks), %0d mismatches",
			results_seen, writebacks_seen, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
